// ===== src/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int SLOT_W    = $clog2(NUM_TASKS);
  localparam int IDX_EXT_W = (SLOT_W > 3) ? SLOT_W : 3;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_START  = 3'd2,
    OP_DELAY  = 3'd3,
    OP_SLEEP  = 3'd4,
    OP_WAKE   = 3'd5,
    OP_EXIT   = 3'd6
  } opcode_t;

  typedef enum logic [2:0] {
    RC_OK   = 3'd0,
    RC_PAR  = 3'd1,
    RC_ID   = 3'd2,
    RC_OBJ  = 3'd3,
    RC_FULL = 3'd4
  } rc_t;

  typedef enum logic [2:0] {
    ST_DORMANT = 3'd0,
    ST_READY   = 3'd1,
    ST_RUNNING = 3'd2,
    ST_DELAY   = 3'd3,
    ST_SLEEP   = 3'd4,
    ST_EXITED  = 3'd5
  } task_st_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_CREATE  = 2'd1,
    ACT_RESCHED = 2'd2
  } act_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic create_step;
    logic tick_start;
    logic scan_step;
    logic dispatch;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    act_t act;
    logic create_done;
    logic scan_done;
  } dp_stat_t;

endpackage

// ===== src/priority_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler_unit
// Fixed-priority preemptive scheduler for pts_pkg::NUM_TASKS task slots.
//
// Input channel (in_valid/in_stall) carries one command beat: opcode, slot,
// priority and signed delay. Result channel (out_valid/out_stall) returns one
// beat per command: status, created slot and the running task afterwards.
// Commands are handled one at a time; in_stall is high from acceptance until
// the result is written to the output register.
// Start, wake, exit and rejected commands pass through decode straight to the
// result; create also checks one slot per cycle while looking for a free
// slot; tick, delay and sleep run the tick step, the dispatch scan that visits
// one slot per cycle, and dispatch before the result.
// A new command is taken while the previous result still waits in the output
// register; a held result blocks only the delivery of the next one.
// Reset clears the tick counter, marks all slots free and dormant and leaves
// no task running. A stalled result holds steady until taken.
// ----------------------------------------------------------------------------
module priority_task_scheduler_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [2:0]         in_task_index,
  input  logic [7:0]         in_priority_req,
  input  logic signed [31:0] in_delay_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [2:0]         out_created_task,
  output logic               out_running_valid,
  output logic [2:0]         out_running_task
);

  pts_pkg::ctl_cmd_t cmd;
  pts_pkg::dp_stat_t stat;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pts_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_opcode),
    .in_task_index     (in_task_index),
    .in_priority_req   (in_priority_req),
    .in_delay_ticks    (in_delay_ticks),
    .out_status        (out_status),
    .out_created_task  (out_created_task),
    .out_running_valid (out_running_valid),
    .out_running_task  (out_running_task)
  );

endmodule

// ===== src/pts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pts_ctrl
// Command sequencer: accepts a beat, steps the datapath, delivers the result.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  pts_pkg::dp_stat_t  stat,
  output pts_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CREATE,
    S_TICK,
    S_SCAN,
    S_DISPATCH,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd             = '0;
    cmd.load        = (state_r == S_IDLE) && in_valid;
    cmd.decode      = (state_r == S_DECODE);
    cmd.create_step = (state_r == S_CREATE);
    cmd.tick_start  = (state_r == S_TICK);
    cmd.scan_step   = (state_r == S_SCAN);
    cmd.dispatch    = (state_r == S_DISPATCH);
    cmd.out_load    = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.act)
          pts_pkg::ACT_CREATE:  state_nxt = S_CREATE;
          pts_pkg::ACT_RESCHED: state_nxt = S_TICK;
          default:              state_nxt = S_DONE;
        endcase
      end
      S_CREATE: begin
        if (stat.create_done) state_nxt = S_DONE;
      end
      S_TICK: state_nxt = S_SCAN;
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: state_nxt = S_DONE;
      S_DONE: begin
        if (cmd.out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== src/pts_datapath.sv =====
// ----------------------------------------------------------------------------
// pts_datapath
// Task table, tick counter, slot scan and result register.
// ----------------------------------------------------------------------------
module pts_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  pts_pkg::ctl_cmd_t  cmd,
  output pts_pkg::dp_stat_t  stat,
  input  logic [2:0]         in_opcode,
  input  logic [2:0]         in_task_index,
  input  logic [7:0]         in_priority_req,
  input  logic signed [31:0] in_delay_ticks,
  output logic [2:0]         out_status,
  output logic [2:0]         out_created_task,
  output logic               out_running_valid,
  output logic [2:0]         out_running_task
);

  localparam int SW = pts_pkg::SLOT_W;
  localparam int XW = pts_pkg::IDX_EXT_W;
  localparam int NT = pts_pkg::NUM_TASKS;
  localparam logic [SW-1:0] LAST = SW'(NT - 1);

  // command beat
  logic [2:0]  op_r;
  logic [2:0]  idx_r;
  logic [7:0]  pri_r;
  logic [31:0] dly_r;

  // scheduler state
  logic [63:0]         tick_r;
  logic                in_use_r [NT];
  pts_pkg::task_st_t   stat_r   [NT];
  logic [SW-1:0]       cur_slot_r;
  logic                cur_valid_r;

  // task tables
  logic [7:0]  pri_mem  [NT];
  logic [63:0] wake_mem [NT];
  logic [7:0]  pri_q;
  logic [63:0] wake_q;

  // scan
  logic [SW-1:0] ptr_r;
  logic          rd_act_r;
  logic          eval_vld_r;
  logic [SW-1:0] eval_ptr_r;
  logic [SW-1:0] best_r;
  logic [7:0]    best_pri_r;
  logic          found_r;

  pts_pkg::rc_t rc_r;
  logic [2:0]   created_r;

  // decode
  logic [XW-1:0]     idx_ext;
  logic [SW-1:0]     idx_slot;
  logic              idx_ok;
  pts_pkg::task_st_t idx_st;
  pts_pkg::rc_t      dec_rc;
  pts_pkg::act_t     dec_act;
  logic              dec_idx_ready;
  logic              dec_set_cur;
  pts_pkg::task_st_t dec_cur_st;
  logic              dec_clr_cur;
  logic              dec_wr_wake;

  logic              slot_free;
  pts_pkg::task_st_t eval_st;
  pts_pkg::task_st_t eval_st_nxt;
  logic              eval_take;
  logic [XW-1:0]     ptr_ext;
  logic [XW-1:0]     cur_ext;

  assign idx_ext  = XW'(idx_r);
  assign idx_slot = idx_ext[SW-1:0];
  assign idx_ok   = ({1'b0, idx_ext} < (XW + 1)'(NT)) && in_use_r[idx_slot];
  assign idx_st   = stat_r[idx_slot];
  assign ptr_ext  = XW'(ptr_r);
  assign cur_ext  = XW'(cur_slot_r);

  always_comb begin
    dec_rc        = pts_pkg::RC_OK;
    dec_act       = pts_pkg::ACT_NONE;
    dec_idx_ready = 1'b0;
    dec_set_cur   = 1'b0;
    dec_cur_st    = pts_pkg::ST_READY;
    dec_clr_cur   = 1'b0;
    dec_wr_wake   = 1'b0;
    unique case (op_r)
      pts_pkg::OP_TICK: dec_act = pts_pkg::ACT_RESCHED;
      pts_pkg::OP_CREATE: begin
        dec_rc  = pts_pkg::RC_FULL;
        dec_act = pts_pkg::ACT_CREATE;
      end
      pts_pkg::OP_START: begin
        if (!idx_ok) begin
          dec_rc = pts_pkg::RC_ID;
        end else if (idx_st != pts_pkg::ST_DORMANT && idx_st != pts_pkg::ST_EXITED) begin
          dec_rc = pts_pkg::RC_OBJ;
        end else begin
          dec_idx_ready = 1'b1;
        end
      end
      pts_pkg::OP_DELAY: begin
        if (!cur_valid_r || dly_r[31]) begin
          dec_rc = pts_pkg::RC_PAR;
        end else begin
          dec_wr_wake = 1'b1;
          dec_set_cur = 1'b1;
          dec_cur_st  = pts_pkg::ST_DELAY;
          dec_act     = pts_pkg::ACT_RESCHED;
        end
      end
      pts_pkg::OP_SLEEP: begin
        if (!cur_valid_r) begin
          dec_rc = pts_pkg::RC_PAR;
        end else begin
          dec_set_cur = 1'b1;
          dec_cur_st  = pts_pkg::ST_SLEEP;
          dec_act     = pts_pkg::ACT_RESCHED;
        end
      end
      pts_pkg::OP_WAKE: begin
        if (!idx_ok) begin
          dec_rc = pts_pkg::RC_ID;
        end else if (idx_st == pts_pkg::ST_SLEEP) begin
          dec_idx_ready = 1'b1;
        end
      end
      pts_pkg::OP_EXIT: begin
        if (!cur_valid_r) begin
          dec_rc = pts_pkg::RC_PAR;
        end else begin
          dec_set_cur = 1'b1;
          dec_cur_st  = pts_pkg::ST_EXITED;
          dec_clr_cur = 1'b1;
        end
      end
      default: dec_rc = pts_pkg::RC_PAR;
    endcase
  end

  assign slot_free = !in_use_r[ptr_r];

  // only the current task can be running, so any running task is demoted
  always_comb begin
    eval_st     = stat_r[eval_ptr_r];
    eval_st_nxt = eval_st;
    if (eval_st == pts_pkg::ST_DELAY && tick_r >= wake_q) eval_st_nxt = pts_pkg::ST_READY;
    if (eval_st == pts_pkg::ST_RUNNING) eval_st_nxt = pts_pkg::ST_READY;
    eval_take = (eval_st_nxt == pts_pkg::ST_READY) && (!found_r || pri_q < best_pri_r);
  end

  assign stat.act         = dec_act;
  assign stat.create_done = slot_free || (ptr_r == LAST);
  assign stat.scan_done   = eval_vld_r && (eval_ptr_r == LAST);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      idx_r <= in_task_index;
      pri_r <= in_priority_req;
      dly_r <= in_delay_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.create_step && slot_free) pri_mem[ptr_r] <= pri_r;
    pri_q <= pri_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.decode && dec_wr_wake) wake_mem[cur_slot_r] <= tick_r + {32'd0, dly_r} + 64'd1;
    wake_q <= wake_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      ptr_r       <= '0;
      rd_act_r    <= 1'b0;
      eval_vld_r  <= 1'b0;
      found_r     <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        in_use_r[i] <= 1'b0;
        stat_r[i]   <= pts_pkg::ST_DORMANT;
      end
    end else begin
      eval_vld_r <= cmd.scan_step && rd_act_r;
      eval_ptr_r <= ptr_r;
      if (cmd.decode) begin
        ptr_r     <= '0;
        rc_r      <= dec_rc;
        created_r <= '0;
        if (dec_idx_ready) stat_r[idx_slot] <= pts_pkg::ST_READY;
        if (dec_set_cur) stat_r[cur_slot_r] <= dec_cur_st;
        if (dec_clr_cur) begin
          cur_valid_r <= 1'b0;
          cur_slot_r  <= '0;
        end
      end
      if (cmd.create_step) begin
        if (slot_free) begin
          in_use_r[ptr_r] <= 1'b1;
          stat_r[ptr_r]   <= pts_pkg::ST_DORMANT;
          rc_r            <= pts_pkg::RC_OK;
          created_r       <= ptr_ext[2:0];
        end else if (ptr_r != LAST) begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      if (cmd.tick_start) begin
        tick_r   <= tick_r + 64'd1;
        ptr_r    <= '0;
        rd_act_r <= 1'b1;
        found_r  <= 1'b0;
      end
      if (cmd.scan_step && rd_act_r) begin
        if (ptr_r == LAST) begin
          rd_act_r <= 1'b0;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      if (eval_vld_r) begin
        stat_r[eval_ptr_r] <= eval_st_nxt;
        if (eval_take) begin
          found_r    <= 1'b1;
          best_r     <= eval_ptr_r;
          best_pri_r <= pri_q;
        end
      end
      if (cmd.dispatch) begin
        if (found_r) begin
          stat_r[best_r] <= pts_pkg::ST_RUNNING;
          cur_slot_r     <= best_r;
          cur_valid_r    <= 1'b1;
        end else begin
          cur_slot_r  <= '0;
          cur_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status        <= rc_r;
      out_created_task  <= created_r;
      out_running_valid <= cur_valid_r;
      out_running_task  <= cur_ext[2:0];
    end
  end

endmodule

// ===== src/pts_checker.sv =====
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks for the priority task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [2:0]  out_created_task,
  input logic        out_running_valid,
  input logic [2:0]  out_running_task
);

  // one command in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("command accepted while another is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == pts_pkg::RC_OK || out_status == pts_pkg::RC_PAR ||
                   out_status == pts_pkg::RC_ID || out_status == pts_pkg::RC_OBJ ||
                   out_status == pts_pkg::RC_FULL))
    else $error("undefined status code");

  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_running_valid) |-> (out_running_task == 3'd0))
    else $error("running slot nonzero while idle");

  a_created_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_created_task != 3'd0) |-> (out_status == pts_pkg::RC_OK))
    else $error("created slot reported on a failed command");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_running_task)))
    else $error("stalled result changed");

endmodule

bind priority_task_scheduler_unit pts_checker u_pts_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_created_task  (out_created_task),
  .out_running_valid (out_running_valid),
  .out_running_task  (out_running_task)
);
